@@ rtl/cpu_alu_8bit_flags_defines.svh @@
// assertion macros for the 8-bit alu block
`ifndef CPU_ALU_8BIT_FLAGS_DEFINES_SVH
`define CPU_ALU_8BIT_FLAGS_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CPUALU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CPUALU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cpualu_pkg.sv @@
// shared types and constants of the 8-bit alu
package cpualu_pkg;

   localparam int CMD_W   = 5;
   localparam int WORD_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 3;
   localparam int FLAG_W  = 4;
   localparam int CLKT_W  = 4;
   localparam int CLKM_W  = 2;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [CLKT_W-1:0] CLKT_SHORT = 4'd4;
   localparam logic [CLKT_W-1:0] CLKT_LONG  = 4'd8;
   localparam logic [CLKM_W-1:0] CLKM_SHORT = 2'd1;
   localparam logic [CLKM_W-1:0] CLKM_LONG  = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INC   = 5'd0,
      CMD_DEC   = 5'd1,
      CMD_SWAP  = 5'd2,
      CMD_ADC   = 5'd3,
      CMD_ADD8  = 5'd4,
      CMD_ADD16 = 5'd5,
      CMD_SUB   = 5'd6,
      CMD_XOR   = 5'd7,
      CMD_AND   = 5'd8,
      CMD_OR    = 5'd9,
      CMD_CP    = 5'd10,
      CMD_BIT   = 5'd11,
      CMD_RES   = 5'd12,
      CMD_SET   = 5'd13,
      CMD_SLA   = 5'd14,
      CMD_SRL   = 5'd15,
      CMD_RL    = 5'd16,
      CMD_RR    = 5'd17,
      CMD_SBC   = 5'd18,
      CMD_SRA   = 5'd19,
      CMD_RLC   = 5'd20,
      CMD_RRC   = 5'd21
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [WORD_W-1:0] operand_a;
      logic [WORD_W-1:0] operand_b;
      logic [POS_W-1:0]  bit_position;
      logic [FLAG_W-1:0] flags_in;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result;
      logic [FLAG_W-1:0] flags_out;
      logic [CLKT_W-1:0] clock_t;
      logic [CLKM_W-1:0] clock_m;
   } rsp_type;

endpackage

@@ rtl/cpualu_req_if.sv @@
// request channel of the 8-bit alu
interface cpualu_req_if;
   logic                            valid;
   logic                            ready;
   logic [cpualu_pkg::CMD_W-1:0]    cmd;
   logic [cpualu_pkg::WORD_W-1:0]   operand_a;
   logic [cpualu_pkg::WORD_W-1:0]   operand_b;
   logic [cpualu_pkg::POS_W-1:0]    bit_position;
   logic [cpualu_pkg::FLAG_W-1:0]   flags_in;

   modport source (output valid, cmd, operand_a, operand_b, bit_position, flags_in,
                   input ready);
   modport sink (input valid, cmd, operand_a, operand_b, bit_position, flags_in,
                 output ready);
endinterface

@@ rtl/cpualu_rsp_if.sv @@
// response channel of the 8-bit alu
interface cpualu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [cpualu_pkg::WORD_W-1:0]   result;
   logic [cpualu_pkg::FLAG_W-1:0]   flags_out;
   logic [cpualu_pkg::CLKT_W-1:0]   clock_t;
   logic [cpualu_pkg::CLKM_W-1:0]   clock_m;

   modport source (output valid, result, flags_out, clock_t, clock_m, input ready);
   modport sink (input valid, result, flags_out, clock_t, clock_m, output ready);
endinterface

@@ rtl/cpu_alu_8bit_flags.sv @@
// 8-bit cpu alu: an accepted request passes stage 1, then stage 2, before response valid
// throughput one request per cycle, back to back, limited only by rsp ready
// stage 1 registers the request, stage 2 registers the alu output
// a full stage 2 under stall still lets stage 1 take one more request
// synchronous active-high reset empties both stages; payload is not reset
module cpu_alu_8bit_flags (
   input  logic                clock,
   input  logic                reset,
   cpualu_req_if.sink          req_bus,
   cpualu_rsp_if.source        rsp_bus
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   cpualu_pkg::req_type s1_data_ff;
   cpualu_pkg::req_type s1_data_in;
   logic                s2_valid_ff;
   logic                s2_valid_in;
   cpualu_pkg::rsp_type s2_data_ff;
   cpualu_pkg::rsp_type s2_data_in;
   cpualu_pkg::req_type req_data;
   cpualu_pkg::rsp_type exec_out;
   logic                advance;
   logic                load;

   assign req_data = '{cmd:          req_bus.cmd,
                       operand_a:    req_bus.operand_a,
                       operand_b:    req_bus.operand_b,
                       bit_position: req_bus.bit_position,
                       flags_in:     req_bus.flags_in};

   cpualu_exec u_exec (
      .req (s1_data_ff),
      .rsp (exec_out)
   );

   assign advance       = !s2_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = load || (s1_valid_ff && !advance);
      s1_data_in  = load ? req_data : s1_data_ff;
      s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;
      s2_data_in  = (advance && s1_valid_ff) ? exec_out : s2_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_bus.valid     = s2_valid_ff;
   assign rsp_bus.result    = s2_data_ff.result;
   assign rsp_bus.flags_out = s2_data_ff.flags_out;
   assign rsp_bus.clock_t   = s2_data_ff.clock_t;
   assign rsp_bus.clock_m   = s2_data_ff.clock_m;

endmodule

@@ rtl/cpualu_exec.sv @@
// alu datapath: result, flags and cycle counts of one request
module cpualu_exec (
   input  cpualu_pkg::req_type req,
   output cpualu_pkg::rsp_type rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        cuse;
   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_half;
   logic [16:0] w_sum;
   logic [12:0] w_half;
   logic [7:0]  pos_mask;
   logic [7:0]  res8;
   logic [3:0]  f;
   logic        long_op;
   logic        wide;

   assign a        = req.operand_a[7:0];
   assign b        = req.operand_b[7:0];
   assign cin      = req.flags_in[cpualu_pkg::FLAG_C];
   assign cuse     = (req.cmd == cpualu_pkg::CMD_ADC || req.cmd == cpualu_pkg::CMD_SBC)
                     ? cin : 1'b0;
   assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, cuse};
   assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cuse};
   assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, cuse};
   assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cuse};
   assign w_sum    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign w_half   = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
   assign pos_mask = 8'd1 << req.bit_position;

   always_comb begin
      res8    = a;
      f       = req.flags_in;
      long_op = 1'b0;
      wide    = 1'b0;
      case (cpualu_pkg::cmd_type'(req.cmd))
         cpualu_pkg::CMD_INC: begin
            res8 = a + 8'd1;
            f    = {res8 == 8'd0, 1'b0, res8[3:0] == 4'd0, cin};
         end
         cpualu_pkg::CMD_DEC: begin
            res8 = a - 8'd1;
            f    = {res8 == 8'd0, 1'b1, res8[3:0] == 4'hF, cin};
         end
         cpualu_pkg::CMD_SWAP: begin
            res8    = {a[3:0], a[7:4]};
            f       = {res8 == 8'd0, 3'b000};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_ADC, cpualu_pkg::CMD_ADD8: begin
            res8 = add_sum[7:0];
            f    = {res8 == 8'd0, 1'b0, add_half[4], add_sum[8]};
         end
         cpualu_pkg::CMD_ADD16: begin
            wide    = 1'b1;
            f       = {req.flags_in[cpualu_pkg::FLAG_Z], 1'b0, w_half[12], w_sum[16]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_SUB, cpualu_pkg::CMD_SBC: begin
            res8 = sub_diff[7:0];
            f    = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
         end
         cpualu_pkg::CMD_CP: begin
            res8 = a;
            f    = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
         end
         cpualu_pkg::CMD_XOR: begin
            res8 = a ^ b;
            f    = {res8 == 8'd0, 3'b000};
         end
         cpualu_pkg::CMD_AND: begin
            res8 = a & b;
            f    = {res8 == 8'd0, 3'b010};
         end
         cpualu_pkg::CMD_OR: begin
            res8 = a | b;
            f    = {res8 == 8'd0, 3'b000};
         end
         cpualu_pkg::CMD_BIT: begin
            f       = {~|(a & pos_mask), 1'b0, 1'b1, cin};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_RES: begin
            res8    = a & ~pos_mask;
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_SET: begin
            res8    = a | pos_mask;
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_SLA: begin
            res8    = {a[6:0], 1'b0};
            f       = {res8 == 8'd0, 2'b00, a[7]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_SRL: begin
            res8    = {1'b0, a[7:1]};
            f       = {res8 == 8'd0, 2'b00, a[0]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_RL: begin
            res8    = {a[6:0], cin};
            f       = {res8 == 8'd0, 2'b00, a[7]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_RR: begin
            res8    = {cin, a[7:1]};
            f       = {res8 == 8'd0, 2'b00, a[0]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_SRA: begin
            res8    = {a[7], a[7:1]};
            f       = {res8 == 8'd0, 2'b00, a[0]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_RLC: begin
            res8    = {a[6:0], a[7]};
            f       = {res8 == 8'd0, 2'b00, a[7]};
            long_op = 1'b1;
         end
         cpualu_pkg::CMD_RRC: begin
            res8    = {a[0], a[7:1]};
            f       = {res8 == 8'd0, 2'b00, a[0]};
            long_op = 1'b1;
         end
         default: begin
            // unassigned codes pass operand and flags through
            wide = 1'b1;
         end
      endcase
   end

   always_comb begin
      if (wide) begin
         rsp.result = (req.cmd == cpualu_pkg::CMD_ADD16) ? w_sum[15:0] : req.operand_a;
      end else begin
         rsp.result = {8'd0, res8};
      end
      rsp.flags_out = f;
      rsp.clock_t   = long_op ? cpualu_pkg::CLKT_LONG : cpualu_pkg::CLKT_SHORT;
      rsp.clock_m   = long_op ? cpualu_pkg::CLKM_LONG : cpualu_pkg::CLKM_SHORT;
   end

endmodule

@@ rtl/cpualu_checker.sv @@
// port-level checks of the 8-bit alu and their bind
`include "cpu_alu_8bit_flags_defines.svh"

module cpualu_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cpualu_pkg::WORD_W-1:0]   rsp_result,
   input logic [cpualu_pkg::FLAG_W-1:0]   rsp_flags_out,
   input logic [cpualu_pkg::CLKT_W-1:0]   rsp_clock_t,
   input logic [cpualu_pkg::CLKM_W-1:0]   rsp_clock_m
);

   // a stalled response holds
   `CPUALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_result) && $stable(rsp_flags_out), "rsp changed under stall")

   // cycle counts agree
   `CPUALU_ASSERT_NOW(a_cycles, clock, reset, rsp_valid,
      (rsp_clock_t == cpualu_pkg::CLKT_LONG && rsp_clock_m == cpualu_pkg::CLKM_LONG) ||
      (rsp_clock_t == cpualu_pkg::CLKT_SHORT && rsp_clock_m == cpualu_pkg::CLKM_SHORT),
      "clock_t and clock_m disagree")

   // no response straight after reset
   `CPUALU_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid,
      "response valid after reset")

   // a draining response side never blocks requests
   `CPUALU_ASSERT_NOW(a_req_ready, clock, reset, !rsp_valid || rsp_ready, req_ready,
      "request stalled while response side drains")

endmodule

bind cpu_alu_8bit_flags cpualu_checker u_cpualu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_result    (rsp_bus.result),
   .rsp_flags_out (rsp_bus.flags_out),
   .rsp_clock_t   (rsp_bus.clock_t),
   .rsp_clock_m   (rsp_bus.clock_m)
);
